// File: rtl/rdq_pkg.sv
`timescale 1ns / 1ps
// Shared constants, command and status codes, and the controller/datapath
// interface structs for the reversible deque. No dependencies.
package rdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [PTR_W-1:0]         t_ptr;
    typedef logic [CNT_W-1:0]         t_cnt;

    localparam logic [2:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_REVERSE    = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;
    localparam logic [2:0] CMD_SPARE_5    = 3'd5;
    localparam logic [2:0] CMD_SPARE_6    = 3'd6;
    localparam logic [2:0] CMD_SPARE_7    = 3'd7;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_VALID = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the accepted command
        logic exec;      // update pointers, write or read the store
        logic load_res;  // load result register with a dataless status
        logic load_pop;  // load result register with the read data
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop_hit;   // current command is a pop on a non-empty store
    } t_dp_stat;

endpackage

// File: rtl/reversible_deque.sv
`timescale 1ns / 1ps
// Reversible double-ended queue, top level. Instantiates rdq_ctrl and
// rdq_datapath; depends on rdq_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries a command i_cmd and a
//   value i_push_value: push back, push front, reverse, pop front, pop back.
//   Output channel (o_out_valid / i_out_stall) returns one result per
//   command: o_status and o_pop_value (zero unless status is popped-valid).
//   Reverse toggles a flag that swaps the ends all later commands act on.
//   A push into a full store is dropped and reported full; a pop on an
//   empty store reports empty.
// Timing:
//   Each accepted command is captured, then executed; push, reverse and failed
//   pops load the result register from the execute state, while a pop that
//   returns data loads it from a further read state; one command is in flight
//   at a time. The read state covers the registered read of the ring store.
//   A new command is taken while the previous result still sits in the
//   output register, provided that result transfers in the same cycle.
// Reset and stall:
//   Synchronous active-low reset empties the queue, clears the reversed flag
//   and drops any pending result; store contents are left as they are.
//   While i_out_stall is high with a result pending, the result holds and no new command is taken.
module reversible_deque
    import rdq_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_cmd,
    input  logic signed [31:0] i_push_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_pop_value
);

    t_dp_cmd  cmd_ctl;
    t_dp_stat dp_stat;

    rdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd_ctl   (cmd_ctl),
        .i_stat      (dp_stat)
    );

    rdq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_ctl    (cmd_ctl),
        .o_stat       (dp_stat),
        .i_cmd        (i_cmd),
        .i_push_value (i_push_value),
        .o_status     (o_status),
        .o_pop_value  (o_pop_value)
    );

endmodule

// File: rtl/rdq_datapath.sv
`timescale 1ns / 1ps
// Datapath of the reversible deque: ring store, head pointer, fill count,
// reversed flag and the result register. Depends on rdq_pkg.
module rdq_datapath
    import rdq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd_ctl,
    output t_dp_stat    o_stat,
    input  logic [2:0]  i_cmd,
    input  t_word       i_push_value,
    output logic [1:0]  o_status,
    output t_word       o_pop_value
);

    t_word      r_mem [DEPTH];
    t_word      r_rd_data;
    logic [2:0] r_cmd;
    t_word      r_val;
    t_ptr       r_head;
    t_cnt       r_count;
    logic       r_rev;
    logic [1:0] r_status;
    t_word      r_pop_value;

    logic       is_push;
    logic       push_at_head;
    logic       is_pop;
    logic       pop_at_head;
    logic       is_rev;
    logic       full;
    logic       empty;
    logic       pop_hit;
    logic       push_ok;
    t_ptr       head_dec;
    t_ptr       head_inc;
    t_ptr       back_push_addr;
    t_ptr       back_pop_addr;
    t_ptr       mem_addr;
    logic [1:0] res_status;

    // fold a sum below 2*DEPTH back into the ring
    function automatic t_ptr wrap_sum(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] d;
        d = (s >= SUM_W'(DEPTH)) ? (s - SUM_W'(DEPTH)) : s;
        return d[PTR_W-1:0];
    endfunction

    always_comb begin
        is_push      = 1'b0;
        push_at_head = 1'b0;
        is_pop       = 1'b0;
        pop_at_head  = 1'b0;
        is_rev       = 1'b0;
        unique case (r_cmd)
            CMD_PUSH_BACK: begin
                is_push      = 1'b1;
                push_at_head = r_rev;
            end
            CMD_PUSH_FRONT: begin
                is_push      = 1'b1;
                push_at_head = ~r_rev;
            end
            CMD_REVERSE: begin
                is_rev = 1'b1;
            end
            CMD_POP_FRONT: begin
                is_pop      = 1'b1;
                pop_at_head = ~r_rev;
            end
            CMD_POP_BACK: begin
                is_pop      = 1'b1;
                pop_at_head = r_rev;
            end
            default: begin
            end
        endcase
    end

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign pop_hit = is_pop & ~empty;
    assign push_ok = is_push & ~full;

    assign head_dec       = (r_head == '0) ? PTR_W'(DEPTH - 1) : (r_head - PTR_W'(1));
    assign head_inc       = wrap_sum(SUM_W'(r_head) + SUM_W'(1));
    assign back_push_addr = wrap_sum(SUM_W'(r_head) + SUM_W'(r_count));
    assign back_pop_addr  = wrap_sum(SUM_W'(r_head) + SUM_W'(r_count) - SUM_W'(1));

    always_comb begin
        if (is_push) begin
            mem_addr = push_at_head ? head_dec : back_push_addr;
        end else begin
            mem_addr = pop_at_head ? r_head : back_pop_addr;
        end
    end

    always_comb begin
        if (is_push && full) begin
            res_status = ST_FULL;
        end else if (is_pop && empty) begin
            res_status = ST_EMPTY;
        end else begin
            res_status = ST_DONE;
        end
    end

    assign o_stat.pop_hit = pop_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.capture) begin
            r_cmd <= i_cmd;
            r_val <= i_push_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_rev   <= 1'b0;
        end else if (i_cmd_ctl.exec) begin
            if (is_rev) begin
                r_rev <= ~r_rev;
            end
            if (push_ok) begin
                if (push_at_head) begin
                    r_head <= head_dec;
                end
                r_count <= r_count + CNT_W'(1);
            end
            if (pop_hit) begin
                if (pop_at_head) begin
                    r_head <= head_inc;
                end
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // single-port ring store, read data registered
    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec && push_ok) begin
            r_mem[mem_addr] <= r_val;
        end
        if (i_cmd_ctl.exec && pop_hit) begin
            r_rd_data <= r_mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.load_res) begin
            r_status    <= res_status;
            r_pop_value <= '0;
        end else if (i_cmd_ctl.load_pop) begin
            r_status    <= ST_VALID;
            r_pop_value <= r_rd_data;
        end
    end

    assign o_status    = r_status;
    assign o_pop_value = r_pop_value;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        SUM_W'(r_head) < SUM_W'(DEPTH))
        else $error("head pointer outside ring");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.exec && is_push && full |=> $stable(r_count) && $stable(r_head))
        else $error("push into full store changed state");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_ctl.exec && pop_hit |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("pop did not reduce fill count");

endmodule

// File: rtl/rdq_ctrl.sv
`timescale 1ns / 1ps
// Controller of the reversible deque: sequences capture, execute and
// result load, and owns both handshakes. Depends on rdq_pkg.
module rdq_ctrl
    import rdq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_dp_cmd  o_cmd_ctl,
    input  t_dp_stat i_stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       in_take;

    // free to take a command in idle once the result register is empty or empties this edge
    assign o_in_stall = ~((r_state == S_IDLE) && (~r_out_valid || ~i_out_stall));
    assign in_take    = i_in_valid & ~o_in_stall;

    always_comb begin
        n_state   = r_state;
        o_cmd_ctl = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    o_cmd_ctl.capture = 1'b1;
                    n_state           = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd_ctl.exec = 1'b1;
                if (i_stat.pop_hit) begin
                    n_state = S_READ;
                end else begin
                    o_cmd_ctl.load_res = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd_ctl.load_pop = 1'b1;
                n_state            = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd_ctl.load_res || o_cmd_ctl.load_pop) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for reversible_deque: a queue-fed command driver, a result
// monitor and an in-bench deque predictor. Depends on rdq_pkg and the RTL.
module tb;
    import rdq_pkg::*;

    typedef struct {
        logic [2:0] cmd;
        t_word      value;
    } t_dq_cmd;

    typedef struct {
        logic [1:0] status;
        t_word      value;
    } t_dq_result;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [2:0] cmd_drv   = CMD_SPARE_7;
    t_word      value_drv = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] status_mon;
    t_word      pop_value_mon;

    t_dq_cmd    cmd_queue[$];
    t_dq_result expected_results[$];

    // predictor state
    t_word      dq_store [DEPTH];
    int         dq_head  = 0;
    int         dq_count = 0;
    logic       dq_rev   = 1'b0;

    int         gen_count    = 0;   // fill level as seen by the generator
    int         total_items  = 0;
    int         sent_count   = 0;
    int         recv_count   = 0;
    int         gap_left     = 0;
    int         gap_max      = 15;
    int         stall_left   = 0;
    int         stall_max    = 15;
    int         error_count  = 0;

    reversible_deque u_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_cmd        (cmd_drv),
        .i_push_value (value_drv),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status_mon),
        .o_pop_value  (pop_value_mon)
    );

    always #5 clk = ~clk;

    task automatic predict_result(input logic [2:0] cmd, input t_word value);
        t_dq_result r;
        logic       at_front;
        r.status = ST_DONE;
        r.value  = '0;
        case (cmd) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                at_front = (cmd == CMD_PUSH_FRONT) ^ dq_rev;
                if (dq_count == DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (at_front) begin
                        dq_head = (dq_head + DEPTH - 1) % DEPTH;
                        dq_store[dq_head] = value;
                    end else begin
                        dq_store[(dq_head + dq_count) % DEPTH] = value;
                    end
                    dq_count++;
                end
            end
            CMD_REVERSE: dq_rev = ~dq_rev;
            CMD_POP_FRONT, CMD_POP_BACK: begin
                at_front = (cmd == CMD_POP_FRONT) ^ dq_rev;
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.status = ST_VALID;
                    if (at_front) begin
                        r.value = dq_store[dq_head];
                        dq_head = (dq_head + 1) % DEPTH;
                    end else begin
                        r.value = dq_store[(dq_head + dq_count - 1) % DEPTH];
                    end
                    dq_count--;
                end
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), r);
    endtask

    // driver: one transfer per accepted edge, random gap after each item
    always @(posedge clk) begin : drive_proc
        t_dq_cmd item;
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (in_valid && !in_stall)
                predict_result(cmd_drv, value_drv);
            if (!in_valid || !in_stall) begin
                if (gap_left != 0 || cmd_queue.size() == 0) begin
                    in_valid <= 1'b0;
                    if (gap_left != 0)
                        gap_left <= gap_left - 1;
                end else begin
                    item = cmd_queue[0];
                    cmd_queue.delete(0);
                    cmd_drv   <= item.cmd;
                    value_drv <= item.value;
                    in_valid  <= 1'b1;
                    sent_count++;
                    if (sent_count % 64 == 0)
                        gap_max = $urandom_range(0, 1) ? 15 : 0;
                    gap_left <= $urandom_range(0, gap_max);
                end
            end
        end
    end

    // monitor: check each result transfer, then hold stall for a random spell
    always @(posedge clk) begin : monitor_proc
        t_dq_result exp_r;
        int         n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: status %0d, pop_value %0d",
                       status_mon, pop_value_mon);
                error_count++;
            end else begin
                exp_r = expected_results[0];
                expected_results.delete(0);
                if (status_mon !== exp_r.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           exp_r.status, status_mon);
                    error_count++;
                end
                if (pop_value_mon !== exp_r.value) begin
                    $error("pop_value mismatch: expected %0d, got %0d",
                           exp_r.value, pop_value_mon);
                    error_count++;
                end
            end
            recv_count++;
            if (recv_count % 64 == 0)
                stall_max = $urandom_range(0, 1) ? 15 : 0;
            n = $urandom_range(0, stall_max);
            stall_left <= n;
            out_stall  <= (n != 0);
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end
    end

    task automatic add_cmd(input logic [2:0] cmd, input t_word value);
        t_dq_cmd item;
        item.cmd   = cmd;
        item.value = value;
        cmd_queue.insert(cmd_queue.size(), item);
        if ((cmd == CMD_PUSH_BACK || cmd == CMD_PUSH_FRONT) && gen_count < DEPTH)
            gen_count++;
        else if ((cmd == CMD_POP_FRONT || cmd == CMD_POP_BACK) && gen_count > 0)
            gen_count--;
    endtask

    function automatic t_word rand_value();
        case ($urandom_range(0, 15))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // spare codes, reverse, then pushes and pops in the given proportion
    task automatic add_random(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            add_cmd(CMD_SPARE_5 + 3'($urandom_range(0, 2)), rand_value());
        else if (r < 8)
            add_cmd(CMD_REVERSE, rand_value());
        else if (r < 8 + push_pct)
            add_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, rand_value());
        else
            add_cmd($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_value());
    endtask

    initial begin
        // directed: empty pops, spare codes, extremes at both ends, reversed order
        add_cmd(CMD_POP_FRONT,  32'sh1234_5678);
        add_cmd(CMD_POP_BACK,   '1);
        add_cmd(CMD_SPARE_5,    32'sh7fff_ffff);
        add_cmd(CMD_SPARE_6,    32'sh8000_0000);
        add_cmd(CMD_SPARE_7,    '1);
        add_cmd(CMD_REVERSE,    '0);
        add_cmd(CMD_POP_FRONT,  '0);
        add_cmd(CMD_REVERSE,    '1);
        add_cmd(CMD_PUSH_FRONT, 32'sh7fff_ffff);   // head wraps below zero
        add_cmd(CMD_PUSH_BACK,  32'sh8000_0000);
        add_cmd(CMD_PUSH_FRONT, '0);
        add_cmd(CMD_PUSH_BACK,  '1);
        add_cmd(CMD_POP_BACK,   '0);
        add_cmd(CMD_POP_FRONT,  '0);
        add_cmd(CMD_REVERSE,    '0);
        add_cmd(CMD_PUSH_BACK,  32'sh5555_5555);
        add_cmd(CMD_PUSH_FRONT, 32'shaaaa_aaaa);
        add_cmd(CMD_SPARE_5,    '0);
        add_cmd(CMD_POP_FRONT,  '0);
        add_cmd(CMD_POP_BACK,   '0);
        add_cmd(CMD_POP_BACK,   '0);
        add_cmd(CMD_POP_FRONT,  '0);
        add_cmd(CMD_POP_FRONT,  '0);
        add_cmd(CMD_REVERSE,    '0);

        repeat (150) add_random(50);

        // fill to the top, then pushes into a full store at both ends
        while (gen_count < DEPTH)
            add_cmd($urandom_range(0, 49) == 0 ? CMD_REVERSE :
                    ($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK),
                    rand_value());
        add_cmd(CMD_PUSH_BACK,  rand_value());
        add_cmd(CMD_PUSH_FRONT, rand_value());
        add_cmd(CMD_REVERSE,    rand_value());
        add_cmd(CMD_PUSH_BACK,  rand_value());
        add_cmd(CMD_PUSH_FRONT, rand_value());
        add_cmd(CMD_POP_FRONT,  rand_value());
        add_cmd(CMD_PUSH_BACK,  rand_value());
        add_cmd(CMD_PUSH_FRONT, rand_value());
        add_cmd(CMD_POP_BACK,   rand_value());
        add_cmd(CMD_PUSH_FRONT, rand_value());

        repeat (100) add_random(30);
        total_items = cmd_queue.size();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // every item gives exactly one result transfer
        while (recv_count < total_items)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("reversible_deque test passed");
        end else begin
            $display("reversible_deque test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("reversible_deque test failed");
        $finish;
    end

endmodule
